>>> design/adx_pkg.sv
// adx_pkg: shared types and constants for the adpcm frame decoder
// no dependencies; imported by adx_adpcm_frame_decoder_core
`timescale 1ns / 1ps

package adx_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_COEF_FIRST   = 2'd0,
        CFG_COEF_SECOND  = 2'd1,
        CFG_STEREO_MODE  = 2'd2,
        CFG_TOTAL_COUNT  = 2'd3
    } t_cfg_idx;

    typedef logic signed [14:0] t_coef;
    typedef logic signed [15:0] t_pcm;

    localparam t_coef COEF_FIRST_RST  = 15'sd7334;
    localparam t_coef COEF_SECOND_RST = -15'sd3283;

    localparam logic signed [20:0] PCM_MAX = 21'sd32767;
    localparam logic signed [20:0] PCM_MIN = -21'sd32768;

    localparam int Q12_SHIFT = 12;

endpackage

>>> design/adx_ram.sv
// adx_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module adx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/adx_adpcm_frame_decoder_core.sv
// adx_adpcm_frame_decoder_core: adx type-3 adpcm byte-stream decoder
// depends on adx_pkg and adx_ram
//
//  channel | direction | handshake                  | beat carries
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_data_byte, i_restart
//  out     | output    | o_out_valid / i_out_ready  | o_pcm_sample, o_channel_index,
//          |           |                            | o_last_of_run, o_stream_end
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a scale byte is stored in idle; a nibble byte runs two nibbles of four steps each on
// the one shared 15x16 multiplier, emitting none for a held left frame, up to one per
// nibble mono, up to two per nibble for a right frame. synchronous active-low reset
// clears state, counters, history, scale, out valid and sets cfg defaults, not the hold
// ram or datapath. output stalls hold the sequencer in its emit state; cfg is always ready.
`timescale 1ns / 1ps

module adx_adpcm_frame_decoder_core
    import adx_pkg::*;
#(
    parameter int FRAME_SAMPLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pcm_sample,
    output logic        o_channel_index,
    output logic        o_last_of_run,
    output logic        o_stream_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int FRAME_BYTES = 2 + FRAME_SAMPLES / 2;
    localparam int PW          = $clog2(FRAME_BYTES + 1);
    localparam int KW          = $clog2(FRAME_SAMPLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_SUM,
        S_EMIT_S,
        S_EMIT_L,
        S_EMIT_R
    } t_state;

    t_state r_state;

    // configuration
    t_coef       r_coef_first;
    t_coef       r_coef_second;
    logic        r_stereo;
    logic [31:0] r_total;

    // run state
    t_pcm        r_h1 [2];
    t_pcm        r_h2 [2];
    t_pcm        r_scale;
    logic [PW-1:0] r_pos;
    logic        r_ch;
    logic [31:0] r_cnt;

    // per-byte work
    logic [7:0]    r_byte;
    logic          r_wch;
    logic          r_hold;
    logic          r_nib;
    logic [KW-2:0] r_kbase;
    logic signed [30:0] r_prod;
    logic signed [31:0] r_acc;
    t_pcm        r_sample;
    logic        r_end;

    // output register
    logic        r_out_valid;
    t_pcm        r_out_pcm;
    logic        r_out_ch;
    logic        r_out_last;
    logic        r_out_end;

    // accept-side decode
    logic          in_acc;
    logic [PW-1:0] pos_eff;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] pos_m2;
    logic          ch_eff;

    // shared multiplier and sum path
    logic [3:0]         nib;
    logic signed [14:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [30:0] mul_p;
    logic signed [20:0] sum;
    t_pcm               sat;

    logic        slot_free;
    logic        out_load;
    logic        cnt_lt;
    logic [31:0] cnt_inc;

    logic [KW-1:0] ram_addr;
    logic          ram_we;
    logic [15:0]   ram_rd;

    assign in_acc  = i_in_valid && o_in_ready;
    assign pos_eff = (i_restart || r_pos >= PW'(FRAME_BYTES)) ? '0 : r_pos;
    assign pos_inc = pos_eff + PW'(1);
    assign pos_m2  = pos_eff - PW'(2);
    assign ch_eff  = i_restart ? 1'b0 : r_ch;

    assign nib = r_nib ? r_byte[3:0] : r_byte[7:4];

    always_comb begin
        unique case (r_state)
            S_MUL_A: begin
                mul_a = r_coef_first;
                mul_b = r_h1[r_wch];
            end
            S_MUL_B: begin
                mul_a = r_coef_second;
                mul_b = r_h2[r_wch];
            end
            default: begin
                mul_a = 15'(signed'(nib));
                mul_b = r_scale;
            end
        endcase
    end

    assign mul_p = 31'(mul_a) * 31'(mul_b);

    // floor division by 4096 is an arithmetic shift
    assign sum = 21'(signed'(r_acc[31:Q12_SHIFT])) + 21'(r_prod);

    always_comb begin
        priority if (sum > PCM_MAX) begin
            sat = 16'sd32767;
        end else if (sum < PCM_MIN) begin
            sat = -16'sd32768;
        end else begin
            sat = 16'(sum);
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;
    // an emit state with a free output slot loads a new beat into the output register this cycle
    assign out_load  = slot_free &&
                       (r_state == S_EMIT_S || r_state == S_EMIT_L || r_state == S_EMIT_R);
    assign cnt_lt    = r_cnt < r_total;
    assign cnt_inc   = r_cnt + 32'd1;

    assign ram_addr = {r_kbase, r_nib};
    assign ram_we   = (r_state == S_SUM) && r_hold;

    adx_ram #(
        .WIDTH (16),
        .DEPTH (FRAME_SAMPLES)
    ) u_hold_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_addr),
        .i_wr_data (sat),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_coef_first  <= COEF_FIRST_RST;
            r_coef_second <= COEF_SECOND_RST;
            r_stereo      <= 1'b0;
            r_total       <= '0;
            r_h1[0]       <= '0;
            r_h1[1]       <= '0;
            r_h2[0]       <= '0;
            r_h2[1]       <= '0;
            r_scale       <= '0;
            r_pos         <= '0;
            r_ch          <= 1'b0;
            r_cnt         <= '0;
            r_nib         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_COEF_FIRST:  r_coef_first  <= i_cfg_data[14:0];
                    CFG_COEF_SECOND: r_coef_second <= i_cfg_data[14:0];
                    CFG_STEREO_MODE: r_stereo      <= i_cfg_data[0];
                    CFG_TOTAL_COUNT: r_total       <= i_cfg_data;
                endcase
            end

            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_restart) begin
                            r_h1[0] <= '0;
                            r_h1[1] <= '0;
                            r_h2[0] <= '0;
                            r_h2[1] <= '0;
                            r_cnt   <= '0;
                        end
                        r_byte  <= i_data_byte;
                        r_wch   <= ch_eff;
                        r_hold  <= !ch_eff && r_stereo;
                        r_nib   <= 1'b0;
                        r_kbase <= pos_m2[KW-2:0];
                        if (pos_eff == '0) begin
                            r_scale <= {i_data_byte, 8'h00};
                        end else if (pos_eff == PW'(1)) begin
                            r_scale[7:0] <= i_data_byte;
                        end else begin
                            r_state <= S_MUL_A;
                        end
                        if (pos_inc >= PW'(FRAME_BYTES)) begin
                            r_pos <= '0;
                            r_ch  <= !ch_eff && r_stereo;
                        end else begin
                            r_pos <= pos_inc;
                            r_ch  <= ch_eff;
                        end
                    end
                end
                S_MUL_A: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_acc   <= 32'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_MUL_C;
                end
                S_MUL_C: begin
                    r_acc   <= r_acc + 32'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_h2[r_wch] <= r_h1[r_wch];
                    r_h1[r_wch] <= sat;
                    r_sample    <= sat;
                    if (!r_hold && cnt_lt) begin
                        r_cnt   <= cnt_inc;
                        r_end   <= (cnt_inc == r_total);
                        r_state <= r_wch ? S_EMIT_L : S_EMIT_S;
                    end else if (!r_nib) begin
                        r_nib   <= 1'b1;
                        r_state <= S_MUL_A;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT_S, S_EMIT_R: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pcm   <= r_sample;
                        r_out_ch    <= (r_state == S_EMIT_R);
                        r_out_end   <= r_end;
                        r_out_last  <= r_nib || r_end;
                        if (!r_nib) begin
                            r_nib   <= 1'b1;
                            r_state <= S_MUL_A;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT_L: begin
                    // left sample from the held frame, always followed by its right
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pcm   <= ram_rd;
                        r_out_ch    <= 1'b0;
                        r_out_end   <= 1'b0;
                        r_out_last  <= 1'b0;
                        r_state     <= S_EMIT_R;
                    end
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_pcm_sample    = r_out_pcm;
    assign o_channel_index = r_out_ch;
    assign o_last_of_run   = r_out_last;
    assign o_stream_end    = r_out_end;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_end) |-> o_last_of_run)
        else $error("stream end beat without last_of_run");

    a_right_after_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_R) |->
            ($past(r_state) == S_EMIT_R || $past(r_state) == S_EMIT_L))
        else $error("right emit not preceded by left emit");

    a_hold_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && r_hold) |=> (r_state == S_MUL_A || r_state == S_IDLE))
        else $error("held left frame tried to emit");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_pcm_sample))
        else $error("output beat overwritten while stalled");

endmodule
